FILE: hw/rtl/ihex_pkg.sv
// Shared types and constants for the Intel HEX record parser.
// No dependencies; used by intel_hex_record_parser_top, ihex_checker and testbench.
package ihex_pkg;

	// Width of the image index counter (one more bit holds the saturated top).
	localparam int INDEX_WIDTH = 16;

	// Record field being read.
	typedef enum logic [2:0] {
		PH_COUNT   = 3'd0,
		PH_ADDR_HI = 3'd1,
		PH_ADDR_LO = 3'd2,
		PH_TYPE    = 3'd3,
		PH_DATA    = 3'd4,
		PH_CHECK   = 3'd5
	} phase_t;

	// Result kinds.
	typedef enum logic [1:0] {
		K_DATA  = 2'd0,
		K_END   = 2'd1,
		K_ERROR = 2'd2
	} kind_t;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] SUM_INVERT = 8'hFF;
	localparam logic [7:0] SUM_ONE    = 8'h01;

endpackage

FILE: hw/rtl/intel_hex_record_parser_top.sv
// Intel HEX record parser: one ASCII character in, at most one result out.
// Depends on ihex_pkg for the phase and result kind types and constants.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one character of HEX text
//   in char_code, with new_image set to restart the image index at zero
//   before that character is used. The output channel (out_valid/out_ready)
//   carries data-byte, record-end and format-error results.
//   Each character is handled in the cycle of its transfer; any result it
//   causes is shown in the output register on the next cycle, and
//   throughput is one character per cycle while the receiver does not stall.
//   The output register parts the two sides: a new character is taken in the
//   same cycle that a waiting result is taken. While the receiver stalls with
//   a result waiting, in_ready drops and the parser state holds.
//   Characters that cause no result never need the output register, but they
//   also wait while it is full.
//   Reset clears the parser to the out-of-record state, the image index to
//   zero and the output register to empty.
//   Characters outside a record other than ':' are ignored. A non-hex
//   character inside a record gives a format error; ':' there also opens a
//   new record at once.
module intel_hex_record_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       new_image,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_value,
	output logic [15:0] data_index,
	output logic [7:0] record_kind,
	output logic       checksum_ok,
	output logic       overflow
);

	localparam int IW = ihex_pkg::INDEX_WIDTH;

	// Parser state.
	logic                 in_record_q;
	ihex_pkg::phase_t     phase_q;
	logic                 digit_q;
	logic [3:0]           high_nibble_q;
	logic [7:0]           bytes_left_q;
	logic [7:0]           type_held_q;
	logic [7:0]           running_sum_q;
	logic [IW:0]          image_index_q;

	// Next state.
	logic                 in_record_d;
	ihex_pkg::phase_t     phase_d;
	logic                 digit_d;
	logic [3:0]           high_nibble_d;
	logic [7:0]           bytes_left_d;
	logic [7:0]           type_held_d;
	logic [7:0]           running_sum_d;
	logic [IW:0]          image_index_d;

	// Result of the current character.
	logic                 emit;
	ihex_pkg::kind_t      res_kind;
	logic [7:0]           res_value;
	logic [15:0]          res_index;
	logic [7:0]           res_rkind;
	logic                 res_ok;
	logic                 res_ovf;

	// Output register.
	logic                 out_valid_q;
	ihex_pkg::kind_t      kind_q;
	logic [7:0]           data_value_q;
	logic [15:0]          data_index_q;
	logic [7:0]           record_kind_q;
	logic                 checksum_ok_q;
	logic                 overflow_q;

	logic                 accept;
	logic                 is_hex;
	logic [3:0]           nib;
	logic [7:0]           byte_val;
	logic [7:0]           left_dec;
	logic [7:0]           sum_add;
	logic [7:0]           expect_sum;
	logic [IW:0]          index_cur;
	logic                 index_top;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Hex digit decode of the incoming character.
	always_comb begin
		is_hex = 1'b1;
		nib    = 4'd0;
		if (char_code >= 8'h30 && char_code <= 8'h39) begin
			nib = 4'(char_code - 8'h30);
		end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
			nib = 4'(char_code - 8'h37);
		end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
			nib = 4'(char_code - 8'h57);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign byte_val   = {high_nibble_q, nib};
	assign left_dec   = bytes_left_q - 8'd1;
	assign sum_add    = running_sum_q + byte_val;
	assign expect_sum = (running_sum_q ^ ihex_pkg::SUM_INVERT) + ihex_pkg::SUM_ONE;
	assign index_cur  = new_image ? '0 : image_index_q;
	assign index_top  = index_cur[IW];

	// Next-state logic for the record parser.
	always_comb begin
		in_record_d   = in_record_q;
		phase_d       = phase_q;
		digit_d       = digit_q;
		high_nibble_d = high_nibble_q;
		bytes_left_d  = bytes_left_q;
		type_held_d   = type_held_q;
		running_sum_d = running_sum_q;
		image_index_d = index_cur;
		if (!in_record_q || !is_hex) begin
			// Outside a record, or a bad character abandoning one.
			in_record_d = 1'b0;
			if (char_code == ihex_pkg::CHAR_COLON) begin
				in_record_d   = 1'b1;
				phase_d       = ihex_pkg::PH_COUNT;
				digit_d       = 1'b0;
				high_nibble_d = 4'd0;
				bytes_left_d  = 8'd0;
				type_held_d   = 8'd0;
				running_sum_d = 8'd0;
			end
		end else if (!digit_q) begin
			high_nibble_d = nib;
			digit_d       = 1'b1;
		end else begin
			digit_d = 1'b0;
			unique case (phase_q)
				ihex_pkg::PH_COUNT: begin
					bytes_left_d  = byte_val;
					running_sum_d = byte_val;
					phase_d       = ihex_pkg::PH_ADDR_HI;
				end
				ihex_pkg::PH_ADDR_HI: begin
					running_sum_d = sum_add;
					phase_d       = ihex_pkg::PH_ADDR_LO;
				end
				ihex_pkg::PH_ADDR_LO: begin
					running_sum_d = sum_add;
					phase_d       = ihex_pkg::PH_TYPE;
				end
				ihex_pkg::PH_TYPE: begin
					type_held_d   = byte_val;
					running_sum_d = sum_add;
					phase_d       = (bytes_left_q == 8'd0) ? ihex_pkg::PH_CHECK
					                                       : ihex_pkg::PH_DATA;
				end
				ihex_pkg::PH_DATA: begin
					running_sum_d = sum_add;
					bytes_left_d  = left_dec;
					if (left_dec == 8'd0) begin
						phase_d = ihex_pkg::PH_CHECK;
					end
					// The index counts up to its top and stays there.
					if (type_held_q == 8'd0 && !index_top) begin
						image_index_d = index_cur + 1'b1;
					end
				end
				default: begin
					// Checksum byte, or a phase code that cannot occur.
					in_record_d = 1'b0;
					phase_d     = ihex_pkg::PH_COUNT;
				end
			endcase
		end
	end

	// Result logic for the current character.
	always_comb begin
		emit      = 1'b0;
		res_kind  = ihex_pkg::K_DATA;
		res_value = 8'd0;
		res_index = 16'd0;
		res_rkind = 8'd0;
		res_ok    = 1'b0;
		res_ovf   = 1'b0;
		if (in_record_q) begin
			if (!is_hex) begin
				emit      = 1'b1;
				res_kind  = ihex_pkg::K_ERROR;
				res_rkind = type_held_q;
			end else if (digit_q) begin
				unique case (phase_q) inside
					ihex_pkg::PH_COUNT, ihex_pkg::PH_ADDR_HI,
					ihex_pkg::PH_ADDR_LO, ihex_pkg::PH_TYPE: begin
						emit = 1'b0;
					end
					ihex_pkg::PH_DATA: begin
						if (type_held_q == 8'd0) begin
							emit      = 1'b1;
							res_value = byte_val;
							res_ovf   = index_top;
							res_index = index_top ? 16'({IW{1'b1}}) : 16'(index_cur);
						end
					end
					ihex_pkg::PH_CHECK: begin
						emit      = 1'b1;
						res_kind  = ihex_pkg::K_END;
						res_rkind = type_held_q;
						res_ok    = (type_held_q != 8'd0) || (expect_sum == byte_val);
					end
					default: begin
						emit      = 1'b1;
						res_kind  = ihex_pkg::K_ERROR;
						res_rkind = type_held_q;
					end
				endcase
			end
		end
	end

	// Parser state registers, updated on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_record_q   <= 1'b0;
			phase_q       <= ihex_pkg::PH_COUNT;
			digit_q       <= 1'b0;
			high_nibble_q <= 4'd0;
			bytes_left_q  <= 8'd0;
			type_held_q   <= 8'd0;
			running_sum_q <= 8'd0;
			image_index_q <= '0;
		end else if (accept) begin
			in_record_q   <= in_record_d;
			phase_q       <= phase_d;
			digit_q       <= digit_d;
			high_nibble_q <= high_nibble_d;
			bytes_left_q  <= bytes_left_d;
			type_held_q   <= type_held_d;
			running_sum_q <= running_sum_d;
			image_index_q <= image_index_d;
		end
	end

	// Output valid: set by a result, cleared when the result is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_q        <= res_kind;
			data_value_q  <= res_value;
			data_index_q  <= res_index;
			record_kind_q <= res_rkind;
			checksum_ok_q <= res_ok;
			overflow_q    <= res_ovf;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_value  = data_value_q;
	assign data_index  = data_index_q;
	assign record_kind = record_kind_q;
	assign checksum_ok = checksum_ok_q;
	assign overflow    = overflow_q;

endmodule

FILE: tb/ihex_checker.sv
// Checker for the Intel HEX record parser: watches both channels, predicts
// every result from the accepted characters and compares results in order.
// Depends on ihex_pkg for the result kinds, record phases and constants.
module ihex_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        new_image,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_value,
	input  logic [15:0] data_index,
	input  logic [7:0]  record_kind,
	input  logic        checksum_ok,
	input  logic        overflow,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Record type whose bytes go into the image and whose checksum is checked.
	localparam logic [7:0] REC_DATA = 8'h00;

	typedef struct packed {
		ihex_pkg::kind_t kind;
		logic [7:0]      value;
		logic [15:0]     index;
		logic [7:0]      rec_type;
		logic            sum_ok;
		logic            ovf;
	} hex_result_t;

	// Parser state as the checker tracks it.
	logic                           open_rec;
	ihex_pkg::phase_t               phase;
	logic                           half_byte;
	logic [3:0]                     upper_nib;
	logic [7:0]                     left_cnt;
	logic [7:0]                     rec_type;
	logic [7:0]                     sum_acc;
	logic [ihex_pkg::INDEX_WIDTH:0] img_pos;
	hex_result_t                    expected_results[$];
	int                             fail_count;

	function automatic int digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	task automatic begin_record();
		open_rec = 1'b1;
		phase = ihex_pkg::PH_COUNT;
		half_byte = 1'b0;
		upper_nib = '0;
		left_cnt = '0;
		rec_type = '0;
		sum_acc = '0;
	endtask

	// Advance the parser state by one accepted character and queue any result.
	task automatic parse_char(input logic [7:0] c, input logic restart);
		int                             nib;
		logic [7:0]                     b;
		logic [7:0]                     want_sum;
		logic [ihex_pkg::INDEX_WIDTH:0] top;
		hex_result_t                    r;
		r = '0;
		top = '0;
		top[ihex_pkg::INDEX_WIDTH] = 1'b1;
		if (restart) img_pos = '0;

		// Outside a record only a colon matters.
		if (!open_rec) begin
			if (c == ihex_pkg::CHAR_COLON) begin_record();
			return;
		end

		// A non-hex character abandons the record; a colon reopens at once.
		nib = digit_value(c);
		if (nib < 0) begin
			r.kind = ihex_pkg::K_ERROR;
			r.rec_type = rec_type;
			expected_results.push_back(r);
			open_rec = 1'b0;
			if (c == ihex_pkg::CHAR_COLON) begin_record();
			return;
		end

		if (!half_byte) begin
			upper_nib = nib[3:0];
			half_byte = 1'b1;
			return;
		end
		half_byte = 1'b0;
		b = {upper_nib, nib[3:0]};

		case (phase)
			ihex_pkg::PH_COUNT: begin
				left_cnt = b;
				sum_acc = b;
				phase = ihex_pkg::PH_ADDR_HI;
			end
			ihex_pkg::PH_ADDR_HI: begin
				sum_acc += b;
				phase = ihex_pkg::PH_ADDR_LO;
			end
			ihex_pkg::PH_ADDR_LO: begin
				sum_acc += b;
				phase = ihex_pkg::PH_TYPE;
			end
			ihex_pkg::PH_TYPE: begin
				rec_type = b;
				sum_acc += b;
				phase = (left_cnt == 0) ? ihex_pkg::PH_CHECK : ihex_pkg::PH_DATA;
			end
			ihex_pkg::PH_DATA: begin
				sum_acc += b;
				left_cnt -= 8'd1;
				if (left_cnt == 0) phase = ihex_pkg::PH_CHECK;
				// Only data records feed the image; the index sticks at its top.
				if (rec_type == REC_DATA) begin
					r.kind = ihex_pkg::K_DATA;
					r.value = b;
					if (img_pos >= top) begin
						img_pos = top;
						r.index = 16'(top - 1'b1);
						r.ovf = 1'b1;
					end else begin
						r.index = 16'(img_pos);
						img_pos += 1'b1;
					end
					expected_results.push_back(r);
				end
			end
			ihex_pkg::PH_CHECK: begin
				want_sum = (sum_acc ^ ihex_pkg::SUM_INVERT) + ihex_pkg::SUM_ONE;
				r.kind = ihex_pkg::K_END;
				r.rec_type = rec_type;
				r.sum_ok = (rec_type == REC_DATA) ? (want_sum == b) : 1'b1;
				expected_results.push_back(r);
				open_rec = 1'b0;
				phase = ihex_pkg::PH_COUNT;
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare one result transfer with the oldest prediction.
	task automatic check_result();
		hex_result_t want;
		if (expected_results.size() == 0) begin
			$error("result transfer with nothing expected: kind %0h", kind);
			fail_count++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("kind", 16'(want.kind), 16'(kind));
		compare_field("data_value", 16'(want.value), 16'(data_value));
		compare_field("data_index", want.index, data_index);
		compare_field("record_kind", 16'(want.rec_type), 16'(record_kind));
		compare_field("checksum_ok", 16'(want.sum_ok), 16'(checksum_ok));
		compare_field("overflow", 16'(want.ovf), 16'(overflow));
	endtask

	// Both channels are sampled at the rising edge; inputs move on the falling one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_rec = 1'b0;
			phase = ihex_pkg::PH_COUNT;
			half_byte = 1'b0;
			upper_nib = '0;
			left_cnt = '0;
			rec_type = '0;
			sum_acc = '0;
			img_pos = '0;
			expected_results.delete();
			fail_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) parse_char(char_code, new_image);
			if (out_valid && out_ready) check_result();
			errors <= fail_count;
			pending <= expected_results.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the Intel HEX record parser testbench: clock, reset and stimulus.
// Depends on ihex_pkg, intel_hex_record_parser_top and ihex_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT = 2_000_000;
	localparam int         HOLD_CYCLES = 300;
	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        new_image;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  data_value;
	logic [15:0] data_index;
	logic [7:0]  record_kind;
	logic        checksum_ok;
	logic        overflow;
	int          errors;
	int          pending;

	int          in_idle_pct;
	int          out_idle_pct;
	int          restart_pct;
	bit          want_hold;
	int          record_chars;
	int          cycle_count;

	intel_hex_record_parser_top uut (.*);

	ihex_checker result_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a run that never drains ends here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: errors");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off when asked.
	initial begin : receiver
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (want_hold && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	function automatic bit pick_restart();
		return $urandom_range(99) < restart_pct;
	endfunction

	// Hex digit in either letter case.
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		if (n < 10) return "0" + n;
		return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
		return c;
	endfunction

	// Offer one character and hold it until the transfer happens.
	task automatic send_char(input logic [7:0] c, input bit restart);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		char_code = c;
		new_image = restart;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text(input string s, input bit restart_first);
		for (int i = 0; i < s.len(); i++) send_char(s[i], restart_first && i == 0);
	endtask

	// Stop offering and wait until every predicted result has come out.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// One record; break_at names the digit position replaced by a non-hex
	// character that cuts the record short, or -1 for a complete record.
	task automatic send_record(input logic [7:0] len, input logic [7:0] rtype,
		input bit good_sum, input int break_at);
		logic [7:0]  fields[$];
		logic [7:0]  sum;
		logic [15:0] addr;
		int          pos;
		addr = 16'($urandom_range(16'hFFFF));
		fields = {len, addr[15:8], addr[7:0], rtype};
		for (int i = 0; i < len; i++) fields.push_back(8'($urandom_range(255)));
		sum = '0;
		foreach (fields[i]) sum += fields[i];
		fields.push_back(good_sum ? (~sum + 8'd1) : 8'($urandom_range(255)));

		send_char(ihex_pkg::CHAR_COLON, pick_restart());
		record_chars++;
		pos = 0;
		foreach (fields[i]) begin
			for (int h = 1; h >= 0; h--) begin
				if (pos == break_at) begin
					send_char(($urandom_range(99) < 30) ? ihex_pkg::CHAR_COLON : non_hex(),
						pick_restart());
					record_chars++;
					return;
				end
				send_char(hex_digit(h ? fields[i][7:4] : fields[i][3:0]), pick_restart());
				record_chars++;
				pos++;
			end
		end
	endtask

	// Mostly well-formed records with random content, some broken, with
	// line ends and junk between them.
	task automatic send_random_record();
		int         len;
		int         roll;
		int         brk;
		logic [7:0] rtype;
		roll = $urandom_range(99);
		len = (roll < 8) ? 0 : (roll < 95) ? $urandom_range(8, 1) : $urandom_range(255, 9);
		roll = $urandom_range(99);
		rtype = (roll < 70) ? REC_DATA : (roll < 85) ? 8'($urandom_range(5, 1)) :
			8'($urandom_range(255));
		brk = ($urandom_range(99) < 10) ? $urandom_range(2 * len + 9) : -1;
		send_record(len, rtype, $urandom_range(99) < 85, brk);
		if ($urandom_range(99) < 25) begin
			if ($urandom_range(1)) begin
				send_char(CHAR_CR, pick_restart());
				send_char(CHAR_LF, pick_restart());
			end else begin
				repeat ($urandom_range(3, 1))
					send_char(8'($urandom_range(255)), pick_restart());
			end
		end
	endtask

	task automatic run_records(input int count);
		int target;
		target = record_chars + count;
		while (record_chars < target) send_random_record();
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		new_image = 1'b0;
		want_hold = 1'b0;
		record_chars = 0;
		in_idle_pct = 22;
		out_idle_pct = 22;
		restart_pct = 3;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: line ends outside a record, a one-byte data record with
		// extreme address and mixed-case digits, an empty end-of-file record
		// with an unchecked checksum, a colon inside a record, a bad digit.
		send_text("\r\n", 1'b0);
		send_text(":01FFFF00aB56", 1'b1);
		send_text(":00000001FE", 1'b0);
		send_text("::G", 1'b0);
		wait_drained();

		run_records(350);

		// Long receiver hold-off while records keep coming.
		want_hold = 1'b1;
		run_records(150);
		wait_drained();

		// A stretch with no idling on either side.
		in_idle_pct = 0;
		out_idle_pct = 0;
		run_records(200);

		in_idle_pct = 22;
		out_idle_pct = 22;
		send_char(CHAR_LF, 1'b1);
		run_records(400);

		wait_drained();
		repeat (4) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
